// File: design/itsc_pkg.sv
// ----------------------------------------------------------------------------
// itsc_pkg
// Shared types and constants of the IP traffic statistics counter.
// ----------------------------------------------------------------------------
`default_nettype none

package itsc_pkg;

  localparam int LENGTH_BINS_DEF  = 21;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam int SCALAR_COUNT = 20;
  localparam int BIN_WIDTH    = 20;

  // length / 20 == (length >> 2) / 5, and x / 5 == (x * 52429) >> 18
  localparam int          LEN_DIV_SHIFT = 18;
  localparam logic [16:0] LEN_DIV_MUL   = 17'd52429;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MODE   = 1'd1;

  localparam int SC_PKT_ALL    = 0;
  localparam int SC_PKT_TCP    = 1;
  localparam int SC_PKT_UDP    = 2;
  localparam int SC_PKT_ICMP   = 3;
  localparam int SC_PKT_IGMP   = 4;
  localparam int SC_BYTES_ALL  = 5;
  localparam int SC_BYTES_TCP  = 6;
  localparam int SC_BYTES_UDP  = 7;
  localparam int SC_BYTES_ICMP = 8;
  localparam int SC_BYTES_IGMP = 9;
  localparam int SC_FRAGS      = 10;
  localparam int SC_FRAG_IP    = 11;
  localparam int SC_FRAG_TCP   = 12;
  localparam int SC_FRAG_UDP   = 13;
  localparam int SC_FLAG_URG   = 14;

  typedef enum logic [2:0] {
    RD_SCALAR,
    RD_HIST_ALL,
    RD_HIST_TCP,
    RD_HIST_UDP,
    RD_BAD
  } rd_sel_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } back_state_e;

  typedef struct packed {
    logic        is_read;
    logic        counted;
    logic        is_tcp;
    logic        is_udp;
    logic        is_icmp;
    logic        is_igmp;
    logic        mf;
    logic [15:0] ident;
    logic [5:0]  flags;
    logic [15:0] len;
    rd_sel_e     rd_sel;
    logic [4:0]  rd_scalar;
  } item_t;

endpackage

`default_nettype wire

// File: design/itsc_in_if.sv
// ----------------------------------------------------------------------------
// itsc_in_if
// Input channel: packet header summary or counter read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface itsc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        is_ipv4;
  logic [31:0] ip_src;
  logic [31:0] ip_dst;
  logic [7:0]  protocol;
  logic [15:0] pkt_len;
  logic        more_fragments;
  logic [15:0] ident;
  logic [5:0]  tcp_flag_bits;
  logic [6:0]  read_index;

  modport source (
    output valid, kind, is_ipv4, ip_src, ip_dst, protocol, pkt_len,
           more_fragments, ident, tcp_flag_bits, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, is_ipv4, ip_src, ip_dst, protocol, pkt_len,
           more_fragments, ident, tcp_flag_bits, read_index,
    output ready
  );
endinterface

`default_nettype wire

// File: design/itsc_out_if.sv
// ----------------------------------------------------------------------------
// itsc_out_if
// Output channel: counter read result.
// ----------------------------------------------------------------------------
`default_nettype none

interface itsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        bad_index;

  modport source (output valid, read_data, bad_index, input ready);
  modport sink (input valid, read_data, bad_index, output ready);
endinterface

`default_nettype wire

// File: design/ip_traffic_statistics_counter.sv
// A read result passes the queue, item register and result register in turn,
// and is held while the output stalls. The engine takes an item only when done
// with the last, as the histogram read-modify-write (registered RAM read, then
// write) spans IDLE and LOOK; a two-entry queue lets input continue on stalls.
// Reset: counters, histogram valid bits, fragment state and config clear at once.
// ----------------------------------------------------------------------------
// ip_traffic_statistics_counter
// Top level: classifier, queue and update engine of the traffic counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_traffic_statistics_counter #(
  parameter int LENGTH_BINS  = itsc_pkg::LENGTH_BINS_DEF,
  parameter int COUNTER_BITS = itsc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [itsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [itsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  itsc_in_if.sink                               in_if,
  itsc_out_if.source                            out_if
);

  localparam int BIN_W = $clog2(LENGTH_BINS);
  localparam int QW    = $bits(itsc_pkg::item_t) + BIN_W;

  itsc_pkg::item_t  f_item, b_item;
  logic [BIN_W-1:0] f_bin, b_bin;
  logic             push, pop, full, q_valid;
  logic [QW-1:0]    q_wdata, q_rdata;

  itsc_front #(.LENGTH_BINS(LENGTH_BINS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if, .full_i(full), .push_o(push), .item_o(f_item), .bin_o(f_bin)
  );

  assign q_wdata = {f_item, f_bin};

  itsc_queue #(.WIDTH(QW), .DEPTH(itsc_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(q_wdata), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_rdata)
  );

  assign {b_item, b_bin} = q_rdata;

  itsc_back #(.LENGTH_BINS(LENGTH_BINS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(b_item), .q_bin_i(b_bin),
    .q_pop_o(pop), .out_if
  );

endmodule

`default_nettype wire

// File: design/itsc_ram.sv
// ----------------------------------------------------------------------------
// itsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_ram #(
  parameter int WIDTH = itsc_pkg::COUNTER_BITS_DEF,
  parameter int DEPTH = itsc_pkg::LENGTH_BINS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/itsc_front.sv
// ----------------------------------------------------------------------------
// itsc_front
// Config registers, input transfer, address match and item classification.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_front #(
  parameter int LENGTH_BINS = itsc_pkg::LENGTH_BINS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [itsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [itsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  itsc_in_if.sink                               in_if,
  input  wire logic                             full_i,
  output logic                                  push_o,
  output itsc_pkg::item_t                       item_o,
  output logic [$clog2(LENGTH_BINS)-1:0]        bin_o
);

  localparam int BIN_W = $clog2(LENGTH_BINS);

  logic [31:0] local_addr_q;
  logic        out_mode_q;

  logic [13:0] len_quads;
  logic [30:0] div_prod;
  logic [12:0] len_div;
  logic [BIN_W-1:0] pkt_bin;
  logic [BIN_W-1:0] rd_bin;
  logic [7:0]  hidx;
  logic        addr_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      out_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        itsc_pkg::CFG_LOCAL_ADDR: local_addr_q <= cfg_data_i[31:0];
        itsc_pkg::CFG_OUT_MODE:   out_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  assign len_quads = in_if.pkt_len[15:2];
  assign div_prod  = 31'({len_quads, 17'd0} >> 17) * 31'(itsc_pkg::LEN_DIV_MUL);
  assign len_div   = div_prod[itsc_pkg::LEN_DIV_SHIFT +: 13];
  assign pkt_bin   = (len_div > 13'(LENGTH_BINS - 1)) ? BIN_W'(LENGTH_BINS - 1)
                                                      : len_div[BIN_W-1:0];

  assign addr_hit = out_mode_q ? (in_if.ip_src == local_addr_q)
                               : (in_if.ip_dst == local_addr_q);

  assign hidx = {1'b0, in_if.read_index} - 8'(itsc_pkg::SCALAR_COUNT);

  always_comb begin
    item_o.is_read   = in_if.kind;
    item_o.counted   = !in_if.kind && in_if.is_ipv4 && addr_hit;
    item_o.is_tcp    = (in_if.protocol == itsc_pkg::PROTO_TCP);
    item_o.is_udp    = (in_if.protocol == itsc_pkg::PROTO_UDP);
    item_o.is_icmp   = (in_if.protocol == itsc_pkg::PROTO_ICMP);
    item_o.is_igmp   = (in_if.protocol == itsc_pkg::PROTO_IGMP);
    item_o.mf        = in_if.more_fragments;
    item_o.ident     = in_if.ident;
    item_o.flags     = in_if.tcp_flag_bits;
    item_o.len       = in_if.pkt_len;
    item_o.rd_scalar = in_if.read_index[4:0];
    rd_bin           = '0;
    if (in_if.read_index < 7'(itsc_pkg::SCALAR_COUNT)) begin
      item_o.rd_sel = itsc_pkg::RD_SCALAR;
    end else if (hidx < 8'(LENGTH_BINS)) begin
      item_o.rd_sel = itsc_pkg::RD_HIST_ALL;
      rd_bin        = hidx[BIN_W-1:0];
    end else if (hidx < 8'(2 * LENGTH_BINS)) begin
      item_o.rd_sel = itsc_pkg::RD_HIST_TCP;
      rd_bin        = BIN_W'(hidx - 8'(LENGTH_BINS));
    end else if (hidx < 8'(3 * LENGTH_BINS)) begin
      item_o.rd_sel = itsc_pkg::RD_HIST_UDP;
      rd_bin        = BIN_W'(hidx - 8'(2 * LENGTH_BINS));
    end else begin
      item_o.rd_sel = itsc_pkg::RD_BAD;
    end
  end

  assign bin_o = in_if.kind ? rd_bin : pkt_bin;

endmodule

`default_nettype wire

// File: design/itsc_queue.sv
// ----------------------------------------------------------------------------
// itsc_queue
// Short register FIFO between the classifier and the update engine.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = itsc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/itsc_back.sv
// ----------------------------------------------------------------------------
// itsc_back
// Update engine: counters, fragment tracking, histogram RMW and read results.
// ----------------------------------------------------------------------------
`default_nettype none

module itsc_back #(
  parameter int LENGTH_BINS  = itsc_pkg::LENGTH_BINS_DEF,
  parameter int COUNTER_BITS = itsc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  input  wire itsc_pkg::item_t                   q_item_i,
  input  wire logic [$clog2(LENGTH_BINS)-1:0]    q_bin_i,
  output logic                                   q_pop_o,
  itsc_out_if.source                             out_if
);

  localparam int BIN_W = $clog2(LENGTH_BINS);
  localparam int CB    = COUNTER_BITS;
  localparam int SUM_W = COUNTER_BITS + 1;
  localparam int NSC   = itsc_pkg::SCALAR_COUNT;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [15:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + SUM_W'(b);
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  itsc_pkg::back_state_e state_q, state_d;
  itsc_pkg::item_t       item_q;
  logic [BIN_W-1:0]      bin_q;

  logic [CB-1:0] cnt_q [NSC];
  logic [CB-1:0] cnt_d [NSC];
  logic [NSC-1:0] inc;
  logic          frag_open_q, frag_open_d;
  logic [15:0]   frag_ident_q, frag_ident_d;

  logic [LENGTH_BINS-1:0] v_all_q, v_tcp_q, v_udp_q;

  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic          out_bad_q;
  logic          out_free;

  logic          upd, load_out;
  logic [BIN_W-1:0] raddr;
  logic [CB-1:0] rd_all, rd_tcp, rd_udp;
  logic [CB-1:0] base_all, base_tcp, base_udp;
  logic [CB-1:0] rd_val;
  logic          we_all, we_tcp, we_udp;

  assign out_free = !out_valid_q || out_if.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itsc_pkg::ST_IDLE: if (q_valid_i) state_d = itsc_pkg::ST_LOOK;
      itsc_pkg::ST_LOOK: if (!item_q.is_read || out_free) state_d = itsc_pkg::ST_IDLE;
      default: state_d = itsc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    upd      = 1'b0;
    load_out = 1'b0;
    case (state_q)
      itsc_pkg::ST_IDLE: q_pop_o = q_valid_i;
      itsc_pkg::ST_LOOK: begin
        upd      = !item_q.is_read && item_q.counted;
        load_out = item_q.is_read && out_free;
      end
      default: ;
    endcase
  end

  assign raddr = (state_q == itsc_pkg::ST_IDLE) ? q_bin_i : bin_q;

  itsc_ram #(.WIDTH(CB), .DEPTH(LENGTH_BINS)) u_hist_all (
    .clk_i, .we_i(we_all), .waddr_i(bin_q), .wdata_i(sat_add(base_all, 16'd1)),
    .raddr_i(raddr), .rdata_o(rd_all)
  );
  itsc_ram #(.WIDTH(CB), .DEPTH(LENGTH_BINS)) u_hist_tcp (
    .clk_i, .we_i(we_tcp), .waddr_i(bin_q), .wdata_i(sat_add(base_tcp, 16'd1)),
    .raddr_i(raddr), .rdata_o(rd_tcp)
  );
  itsc_ram #(.WIDTH(CB), .DEPTH(LENGTH_BINS)) u_hist_udp (
    .clk_i, .we_i(we_udp), .waddr_i(bin_q), .wdata_i(sat_add(base_udp, 16'd1)),
    .raddr_i(raddr), .rdata_o(rd_udp)
  );

  // entries never written read as zero
  assign base_all = v_all_q[bin_q] ? rd_all : '0;
  assign base_tcp = v_tcp_q[bin_q] ? rd_tcp : '0;
  assign base_udp = v_udp_q[bin_q] ? rd_udp : '0;

  assign we_all = upd;
  assign we_tcp = upd && item_q.is_tcp;
  assign we_udp = upd && item_q.is_udp;

  always_comb begin
    inc          = '0;
    frag_open_d  = frag_open_q;
    frag_ident_d = frag_ident_q;
    if (upd) begin
      inc[itsc_pkg::SC_PKT_ALL]   = 1'b1;
      inc[itsc_pkg::SC_BYTES_ALL] = 1'b1;
      if (item_q.is_tcp) begin
        inc[itsc_pkg::SC_PKT_TCP]   = 1'b1;
        inc[itsc_pkg::SC_BYTES_TCP] = 1'b1;
      end else if (item_q.is_udp) begin
        inc[itsc_pkg::SC_PKT_UDP]   = 1'b1;
        inc[itsc_pkg::SC_BYTES_UDP] = 1'b1;
      end else if (item_q.is_icmp) begin
        inc[itsc_pkg::SC_PKT_ICMP]   = 1'b1;
        inc[itsc_pkg::SC_BYTES_ICMP] = 1'b1;
      end else if (item_q.is_igmp) begin
        inc[itsc_pkg::SC_PKT_IGMP]   = 1'b1;
        inc[itsc_pkg::SC_BYTES_IGMP] = 1'b1;
      end
      if (item_q.mf) begin
        inc[itsc_pkg::SC_FRAGS] = 1'b1;
        if (!frag_open_q) begin
          inc[itsc_pkg::SC_FRAG_IP]  = 1'b1;
          inc[itsc_pkg::SC_FRAG_TCP] = item_q.is_tcp;
          inc[itsc_pkg::SC_FRAG_UDP] = item_q.is_udp;
          frag_open_d  = 1'b1;
          frag_ident_d = item_q.ident;
        end
      end else if (frag_open_q && (frag_ident_q == item_q.ident)) begin
        inc[itsc_pkg::SC_FRAGS] = 1'b1;
        frag_open_d = 1'b0;
      end
      if (item_q.is_tcp) begin
        for (int b = 0; b < 6; b++) begin
          inc[itsc_pkg::SC_FLAG_URG + b] = item_q.flags[5 - b];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NSC; i++) begin
      if (!inc[i]) begin
        cnt_d[i] = cnt_q[i];
      end else if (i >= itsc_pkg::SC_BYTES_ALL && i <= itsc_pkg::SC_BYTES_IGMP) begin
        cnt_d[i] = sat_add(cnt_q[i], item_q.len);
      end else begin
        cnt_d[i] = sat_add(cnt_q[i], 16'd1);
      end
    end
  end

  always_comb begin
    case (item_q.rd_sel)
      itsc_pkg::RD_SCALAR:   rd_val = cnt_q[item_q.rd_scalar];
      itsc_pkg::RD_HIST_ALL: rd_val = base_all;
      itsc_pkg::RD_HIST_TCP: rd_val = base_tcp;
      itsc_pkg::RD_HIST_UDP: rd_val = base_udp;
      default:               rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= itsc_pkg::ST_IDLE;
      frag_open_q  <= 1'b0;
      frag_ident_q <= '0;
      v_all_q      <= '0;
      v_tcp_q      <= '0;
      v_udp_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NSC; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      frag_open_q  <= frag_open_d;
      frag_ident_q <= frag_ident_d;
      cnt_q        <= cnt_d;
      if (we_all) v_all_q[bin_q] <= 1'b1;
      if (we_tcp) v_tcp_q[bin_q] <= 1'b1;
      if (we_udp) v_udp_q[bin_q] <= 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      bin_q  <= q_bin_i;
    end
    if (load_out) begin
      out_data_q <= 32'(rd_val);
      out_bad_q  <= (item_q.rd_sel == itsc_pkg::RD_BAD);
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.read_data = out_data_q;
  assign out_if.bad_index = out_bad_q;

`ifndef ASSERT_OFF
  a_pop_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == itsc_pkg::ST_LOOK)
    else $error("pop did not start lookup");

  a_load_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> item_q.is_read && !we_all && !we_tcp && !we_udp)
    else $error("result loaded for a packet item");

  a_series_open_mf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(frag_open_q) |-> $past(item_q.mf) && $past(upd))
    else $error("fragment series opened without more-fragments");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && item_q.rd_sel == itsc_pkg::RD_BAD |=> out_data_q == '0 && out_bad_q)
    else $error("bad index result not zero");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itsc_pkg::ST_LOOK && item_q.is_read && !out_free |=> !q_pop_o)
    else $error("new item taken while result stalled");
`endif

endmodule

`default_nettype wire

// File: tb/ip_traffic_statistics_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_traffic_statistics_counter_tb
// Drives header summaries and counter reads with random gaps and output
// stalls. A local copy of the counters predicts every read result, and each
// result transfer is checked field by field against it.
// ----------------------------------------------------------------------------

module ip_traffic_statistics_counter_tb;

  localparam int  NUM_BINS      = itsc_pkg::LENGTH_BINS_DEF;
  localparam int  HIST_TOTAL    = 3 * NUM_BINS;
  localparam int  NUM_COUNTERS  = itsc_pkg::SCALAR_COUNT + HIST_TOTAL;
  localparam int  TCP_FLAG_BITS = 6;
  localparam int  DRAIN_CYCLES  = 16;
  localparam int  STALL_LIMIT   = 1000;
  localparam int  RANDOM_ITEMS  = 350;
  localparam int  BURST_ITEMS   = 100;
  localparam logic KIND_PKT     = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        is_ipv4;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [7:0]  protocol;
    logic [15:0] pkt_len;
    logic        more_fragments;
    logic [15:0] ident;
    logic [5:0]  tcp_flag_bits;
    logic [6:0]  read_index;
  } hdr_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_index;
  } read_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [itsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [itsc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  itsc_in_if  in_ch ();
  itsc_out_if out_ch ();

  ip_traffic_statistics_counter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Predicted counter state
  logic [31:0]  cnt_scalar [itsc_pkg::SCALAR_COUNT];
  logic [31:0]  cnt_hist   [HIST_TOTAL];
  logic         frag_open;
  logic [15:0]  frag_ident_q;
  logic [31:0]  mon_addr;
  logic         mon_outgoing;

  read_result_t read_q [$];
  read_result_t got_exp;
  int           fail_count = 0;
  int           idle_cycles = 0;
  logic         src_steady = 1'b0;
  logic         sink_steady = 1'b0;
  logic [15:0]  frag_key;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic count_proto(input int pkt_slot, input int byte_slot, input logic [15:0] len);
    cnt_scalar[pkt_slot]  = sat_add(cnt_scalar[pkt_slot], 32'd1);
    cnt_scalar[byte_slot] = sat_add(cnt_scalar[byte_slot], {16'd0, len});
  endtask

  task automatic bump_scalar(input int slot);
    cnt_scalar[slot] = sat_add(cnt_scalar[slot], 32'd1);
  endtask

  task automatic account_item(input hdr_item_t it);
    read_result_t res;
    logic         hit;
    int           len_bin;
    if (it.kind == KIND_READ) begin
      res.read_data = '0;
      res.bad_index = 1'b0;
      if (it.read_index < itsc_pkg::SCALAR_COUNT) begin
        res.read_data = cnt_scalar[it.read_index];
      end else if (it.read_index < NUM_COUNTERS) begin
        res.read_data = cnt_hist[it.read_index - itsc_pkg::SCALAR_COUNT];
      end else begin
        res.bad_index = 1'b1;
      end
      read_q.push_back(res);
      return;
    end
    hit = mon_outgoing ? (it.ip_src == mon_addr) : (it.ip_dst == mon_addr);
    if (!it.is_ipv4 || !hit) return;

    count_proto(itsc_pkg::SC_PKT_ALL, itsc_pkg::SC_BYTES_ALL, it.pkt_len);
    case (it.protocol)
      itsc_pkg::PROTO_TCP:
        count_proto(itsc_pkg::SC_PKT_TCP, itsc_pkg::SC_BYTES_TCP, it.pkt_len);
      itsc_pkg::PROTO_UDP:
        count_proto(itsc_pkg::SC_PKT_UDP, itsc_pkg::SC_BYTES_UDP, it.pkt_len);
      itsc_pkg::PROTO_ICMP:
        count_proto(itsc_pkg::SC_PKT_ICMP, itsc_pkg::SC_BYTES_ICMP, it.pkt_len);
      itsc_pkg::PROTO_IGMP:
        count_proto(itsc_pkg::SC_PKT_IGMP, itsc_pkg::SC_BYTES_IGMP, it.pkt_len);
      default: ;
    endcase

    if (it.more_fragments) begin
      bump_scalar(itsc_pkg::SC_FRAGS);
      if (!frag_open) begin
        bump_scalar(itsc_pkg::SC_FRAG_IP);
        if (it.protocol == itsc_pkg::PROTO_TCP) bump_scalar(itsc_pkg::SC_FRAG_TCP);
        else if (it.protocol == itsc_pkg::PROTO_UDP) bump_scalar(itsc_pkg::SC_FRAG_UDP);
        frag_open    = 1'b1;
        frag_ident_q = it.ident;
      end
    end else if (frag_open && frag_ident_q == it.ident) begin
      bump_scalar(itsc_pkg::SC_FRAGS);
      frag_open = 1'b0;
    end

    len_bin = it.pkt_len / itsc_pkg::BIN_WIDTH;
    if (len_bin > NUM_BINS - 1) len_bin = NUM_BINS - 1;
    cnt_hist[len_bin] = sat_add(cnt_hist[len_bin], 32'd1);
    if (it.protocol == itsc_pkg::PROTO_TCP) begin
      cnt_hist[NUM_BINS + len_bin] = sat_add(cnt_hist[NUM_BINS + len_bin], 32'd1);
    end else if (it.protocol == itsc_pkg::PROTO_UDP) begin
      cnt_hist[2 * NUM_BINS + len_bin] = sat_add(cnt_hist[2 * NUM_BINS + len_bin], 32'd1);
    end

    if (it.protocol == itsc_pkg::PROTO_TCP) begin
      for (int b = 0; b < TCP_FLAG_BITS; b++) begin
        if (it.tcp_flag_bits[b]) bump_scalar(itsc_pkg::SC_FLAG_URG + TCP_FLAG_BITS - 1 - b);
      end
    end
  endtask

  // Matched packet for the current address and direction
  function automatic hdr_item_t mk_pkt(input logic [7:0] proto, input logic [15:0] len,
                                       input logic mf, input logic [15:0] id,
                                       input logic [5:0] flags);
    hdr_item_t it;
    it.kind           = KIND_PKT;
    it.is_ipv4        = 1'b1;
    it.ip_src         = $urandom;
    it.ip_dst         = $urandom;
    it.protocol       = proto;
    it.pkt_len        = len;
    it.more_fragments = mf;
    it.ident          = id;
    it.tcp_flag_bits  = flags;
    it.read_index     = 7'($urandom_range(0, 127));
    if (mon_outgoing) it.ip_src = mon_addr;
    else it.ip_dst = mon_addr;
    return it;
  endfunction

  function automatic hdr_item_t mk_read(input logic [6:0] idx);
    hdr_item_t it;
    it            = mk_pkt(8'($urandom_range(0, 255)), 16'($urandom), 1'($urandom),
                           16'($urandom), 6'($urandom));
    it.is_ipv4    = 1'($urandom);
    it.kind       = KIND_READ;
    it.read_index = idx;
    return it;
  endfunction

  function automatic hdr_item_t rand_item();
    hdr_item_t it;
    int        r;
    logic [7:0]  proto;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 30) proto = itsc_pkg::PROTO_TCP;
    else if (r < 55) proto = itsc_pkg::PROTO_UDP;
    else if (r < 65) proto = itsc_pkg::PROTO_ICMP;
    else if (r < 75) proto = itsc_pkg::PROTO_IGMP;
    else proto = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 70) len = 16'($urandom_range(0, 499));
    else if (r < 90) len = 16'($urandom);
    else if (r < 95) len = 16'hFFFF;
    else len = 16'($urandom_range(380, 440));
    it = mk_pkt(proto, len, $urandom_range(0, 2) == 0,
                ($urandom_range(0, 3) != 0) ? frag_key : 16'($urandom), 6'($urandom));
    it.is_ipv4 = $urandom_range(0, 9) != 0;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it = mk_read(7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, NUM_COUNTERS - 1)));
    end else if (r < 25) begin
      it.ip_src = $urandom;
      it.ip_dst = $urandom;
    end else if (r < 30) begin
      it.ip_src = mon_addr;
      it.ip_dst = mon_addr;
    end
    return it;
  endfunction

  task automatic send_item(input hdr_item_t it);
    int gap;
    gap = (src_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= it.kind;
    in_ch.is_ipv4        <= it.is_ipv4;
    in_ch.ip_src         <= it.ip_src;
    in_ch.ip_dst         <= it.ip_dst;
    in_ch.protocol       <= it.protocol;
    in_ch.pkt_len        <= it.pkt_len;
    in_ch.more_fragments <= it.more_fragments;
    in_ch.ident          <= it.ident;
    in_ch.tcp_flag_bits  <= it.tcp_flag_bits;
    in_ch.read_index     <= it.read_index;
    do @(posedge clk_i); while (!in_ch.ready);
    account_item(it);
  endtask

  // Quiesce the block: no input, all reads returned, queued packets retired
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (read_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [itsc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == itsc_pkg::CFG_LOCAL_ADDR) mon_addr = data;
    else mon_outgoing = data[0];
  endtask

  task automatic set_mode(input logic [31:0] addr, input logic outgoing);
    drain();
    write_reg(itsc_pkg::CFG_LOCAL_ADDR, addr);
    write_reg(itsc_pkg::CFG_OUT_MODE, {31'd0, outgoing});
  endtask

  task automatic read_counters();
    for (int i = 0; i < NUM_COUNTERS; i++) send_item(mk_read(7'(i)));
    send_item(mk_read(7'(NUM_COUNTERS)));
    send_item(mk_read(7'h7F));
  endtask

  task automatic test_reset_values();
    read_counters();
  endtask

  task automatic test_directed_incoming();
    hdr_item_t it;
    set_mode(32'hC0A8_0001, 1'b0);
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd0, 1'b0, 16'd0, 6'h3F));
    send_item(mk_pkt(itsc_pkg::PROTO_UDP, 16'hFFFF, 1'b0, 16'd0, 6'h3F));
    send_item(mk_pkt(itsc_pkg::PROTO_ICMP, 16'd19, 1'b0, 16'd0, 6'h00));
    send_item(mk_pkt(itsc_pkg::PROTO_IGMP, 16'd20, 1'b0, 16'd0, 6'h00));
    send_item(mk_pkt(8'hFF, 16'd399, 1'b0, 16'd0, 6'h3F));
    send_item(mk_pkt(8'h00, 16'd400, 1'b0, 16'd0, 6'h00));
    // fragment series: open, continue, foreign final, matching final, stray final
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd1500, 1'b1, 16'hFFFF, 6'h15));
    send_item(mk_pkt(itsc_pkg::PROTO_UDP, 16'd1500, 1'b1, 16'h0001, 6'h2A));
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd60, 1'b0, 16'h0002, 6'h00));
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd60, 1'b0, 16'hFFFF, 6'h00));
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd60, 1'b0, 16'hFFFF, 6'h00));
    send_item(mk_pkt(itsc_pkg::PROTO_UDP, 16'd576, 1'b1, 16'h0000, 6'h00));
    it = mk_pkt(itsc_pkg::PROTO_TCP, 16'd40, 1'b0, 16'h0000, 6'h3F);
    it.ip_src = mon_addr;
    it.ip_dst = ~mon_addr;
    send_item(it);
    it = mk_pkt(itsc_pkg::PROTO_TCP, 16'd40, 1'b0, 16'h0000, 6'h3F);
    it.is_ipv4 = 1'b0;
    send_item(it);
    send_item(mk_pkt(itsc_pkg::PROTO_ICMP, 16'd84, 1'b0, 16'h0000, 6'h00));
    read_counters();
  endtask

  task automatic test_outgoing_mode();
    hdr_item_t it;
    set_mode(32'hFFFF_FFFF, 1'b1);
    send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'd52, 1'b0, 16'h1234, 6'h12));
    it = mk_pkt(itsc_pkg::PROTO_UDP, 16'd52, 1'b0, 16'h1234, 6'h00);
    it.ip_src = ~mon_addr;
    it.ip_dst = mon_addr;
    send_item(it);
    send_item(mk_read(7'(itsc_pkg::SC_PKT_ALL)));
    send_item(mk_read(7'(itsc_pkg::SC_PKT_TCP)));
    send_item(mk_read(7'(itsc_pkg::SC_PKT_UDP)));
    set_mode(32'h0000_0000, 1'b1);
    send_item(mk_pkt(itsc_pkg::PROTO_UDP, 16'd1000, 1'b0, 16'h0000, 6'h00));
    send_item(mk_read(7'(itsc_pkg::SC_PKT_UDP)));
    send_item(mk_read(7'(itsc_pkg::SC_BYTES_UDP)));
  endtask

  task automatic run_phase(input logic [31:0] addr, input logic outgoing);
    set_mode(addr, outgoing);
    frag_key = 16'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) src_steady = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 19) == 0) frag_key = 16'($urandom);
      send_item(rand_item());
    end
    src_steady = 1'b0;
    read_counters();
  endtask

  task automatic test_random_traffic();
    run_phase($urandom, 1'b0);
    run_phase($urandom, 1'b1);
    run_phase(32'h0000_0000, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_back_to_back();
    set_mode(32'h0A00_0002, 1'b0);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    for (int k = 0; k < BURST_ITEMS; k++) begin
      if (k % 4 == 3) send_item(mk_read(7'(k % NUM_COUNTERS)));
      else send_item(mk_pkt(itsc_pkg::PROTO_TCP, 16'hFFFF, 1'b0, 16'h0000, 6'h00));
    end
    send_item(mk_pkt(itsc_pkg::PROTO_UDP, 16'hFFFF, 1'b0, 16'h0000, 6'h00));
    send_item(mk_read(7'(itsc_pkg::SC_BYTES_ALL)));
    send_item(mk_read(7'(itsc_pkg::SC_BYTES_TCP)));
    send_item(mk_read(7'(itsc_pkg::SC_PKT_ALL)));
    send_item(mk_read(7'(itsc_pkg::SCALAR_COUNT + NUM_BINS - 1)));
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Result side: random stalls with long ready stretches
  initial begin
    int run;
    run          = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_steady) begin
        out_ch.ready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        run = idle_len();
      end else begin
        out_ch.ready <= 1'b1;
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (read_q.size() == 0) begin
        $error("unexpected read result: read_data %h bad_index %b",
               out_ch.read_data, out_ch.bad_index);
        fail_count++;
      end else begin
        got_exp = read_q.pop_front();
        if (out_ch.read_data !== got_exp.read_data) begin
          $error("read_data: expected %h, actual %h", got_exp.read_data, out_ch.read_data);
          fail_count++;
        end
        if (out_ch.bad_index !== got_exp.bad_index) begin
          $error("bad_index: expected %b, actual %b", got_exp.bad_index, out_ch.bad_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL ip_traffic_statistics_counter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_PKT;
    in_ch.is_ipv4        = 1'b0;
    in_ch.ip_src         = '0;
    in_ch.ip_dst         = '0;
    in_ch.protocol       = '0;
    in_ch.pkt_len        = '0;
    in_ch.more_fragments = 1'b0;
    in_ch.ident          = '0;
    in_ch.tcp_flag_bits  = '0;
    in_ch.read_index     = '0;
    cnt_scalar           = '{default: '0};
    cnt_hist             = '{default: '0};
    frag_open            = 1'b0;
    frag_ident_q         = '0;
    mon_addr             = '0;
    mon_outgoing         = 1'b0;
    frag_key             = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed_incoming();
    test_outgoing_mode();
    test_random_traffic();
    test_back_to_back();
    drain();

    if (fail_count == 0) begin
      $display("PASS ip_traffic_statistics_counter");
    end else begin
      $display("FAIL ip_traffic_statistics_counter");
    end
    $finish;
  end

endmodule
